### rtl/temp_to_rgb_duty_mapper_assert.svh
// Assertion macros for the colour mapper.
`ifndef TEMP_TO_RGB_DUTY_MAPPER_ASSERT_SVH
`define TEMP_TO_RGB_DUTY_MAPPER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define TTRGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttrgb: property failed");

// Consequent holds in the cycle after the antecedent.
`define TTRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttrgb: property failed");

`endif

### rtl/ttrgb_pkg.sv
`default_nettype none
package ttrgb_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TEMP_W   = 10;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned SAMPLE_MAX = 1023;

  localparam logic [SCALE_W-1:0] TEMP_SCALE_RST = 16'd21119;
  localparam logic [DUTY_W-1:0]  DUTY_FULL      = 10'd1023;

  localparam int unsigned RED_LO     = 45;
  localparam int unsigned RED_HI     = 90;
  localparam int unsigned GREEN_LO   = 15;
  localparam int unsigned GREEN_PEAK = 35;
  localparam int unsigned GREEN_HI   = 75;
  localparam int unsigned BLUE_HI    = 45;

  localparam int unsigned SLOPE_UP   = 1022;
  localparam int unsigned SLOPE_DOWN = 1023;

  localparam int unsigned DIV_RED   = 45;
  localparam int unsigned DIV_GREEN = 20;
  localparam int unsigned DIV_BLUE  = 45;

  localparam logic [NUM_W-1:0] RECIP_RED   = NUM_W'((2 ** NUM_W) / DIV_RED);
  localparam logic [NUM_W-1:0] RECIP_GREEN = NUM_W'((2 ** NUM_W) / DIV_GREEN);
  localparam logic [NUM_W-1:0] RECIP_BLUE  = NUM_W'((2 ** NUM_W) / DIV_BLUE);

  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QPTR_W;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_AVG_EST,
    BE_AVG_FIX,
    BE_SCALE,
    BE_RAMP_NUM,
    BE_RAMP_EST,
    BE_RAMP_FIX
  } be_state_e;

endpackage
`default_nettype wire

### rtl/ttrgb_sample_if.sv
`default_nettype none
interface ttrgb_sample_if;
  logic                             valid;
  logic                             ready;
  logic [ttrgb_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

### rtl/ttrgb_result_if.sv
`default_nettype none
interface ttrgb_result_if;
  logic                           valid;
  logic                           ready;
  logic [ttrgb_pkg::TEMP_W-1:0]   temperature;
  logic [ttrgb_pkg::DUTY_W-1:0]   red_duty;
  logic [ttrgb_pkg::DUTY_W-1:0]   green_duty;
  logic [ttrgb_pkg::DUTY_W-1:0]   blue_duty;

  modport source (output valid, output temperature, output red_duty, output green_duty,
                  output blue_duty, input ready);
  modport sink   (input valid, input temperature, input red_duty, input green_duty,
                  input blue_duty, output ready);
endinterface
`default_nettype wire

### rtl/ttrgb_cfg_if.sv
`default_nettype none
interface ttrgb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ttrgb_pkg::SCALE_W-1:0]   temp_scale;

  modport source (output valid, output temp_scale, input ready);
  modport sink   (input valid, input temp_scale, output ready);
endinterface
`default_nettype wire

### rtl/temp_to_rgb_duty_mapper.sv
// Each block sum goes through a 2-entry queue and the back end states AVG_EST, AVG_FIX,
// SCALE, RAMP_NUM, RAMP_EST, RAMP_FIX (held while the output stalls) to the output.
// One sample per cycle while the queue has room; the back end takes a block at a time.
// Reset (asynchronous, active low) clears the block sum and count, the queue and the
// sequencer, and sets temp_scale to 21119; no clearing pass follows.
`default_nettype none
`include "temp_to_rgb_duty_mapper_assert.svh"
module temp_to_rgb_duty_mapper #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ttrgb_cfg_if.sink       cfg_i,
  ttrgb_sample_if.sink    sample_i,
  ttrgb_result_if.source  result_o
);
  import ttrgb_pkg::*;

  localparam int unsigned SUM_W = $clog2(SAMPLES_PER_AVERAGE * SAMPLE_MAX + 1);

  logic [SCALE_W-1:0] temp_scale_q;
  logic               push_valid, push_ready;
  logic [SUM_W-1:0]   push_sum;
  logic               pop_valid, pop_ready;
  logic [SUM_W-1:0]   pop_sum;
  logic               push_stall;
  logic               hot_result, hot_duties;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_scale_q <= TEMP_SCALE_RST;
    end else if (cfg_i.valid) begin
      temp_scale_q <= cfg_i.temp_scale;
    end
  end

  ttrgb_front #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SUM_W               (SUM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_sum_o   (push_sum)
  );

  ttrgb_queue #(
    .WIDTH (SUM_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_sum),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_sum)
  );

  ttrgb_back #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SUM_W               (SUM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_sum_i    (pop_sum),
    .temp_scale_i (temp_scale_q),
    .result_o     (result_o)
  );

  assign push_stall = push_valid && !push_ready;
  assign hot_result = result_o.valid && result_o.temperature > TEMP_W'(RED_HI);
  assign hot_duties = result_o.red_duty == DUTY_FULL && result_o.green_duty == '0
                      && result_o.blue_duty == '0;

  `TTRGB_ASSERT_NOW(a_full_queue_stalls_input, clk_i, rst_ni, push_stall, !sample_i.ready)
  `TTRGB_ASSERT_NEXT(a_one_block_at_a_time, clk_i, rst_ni, pop_valid && pop_ready, !pop_ready)
  `TTRGB_ASSERT_NOW(a_hot_colours, clk_i, rst_ni, hot_result, hot_duties)

endmodule
`default_nettype wire

### rtl/ttrgb_front.sv
`default_nettype none
module ttrgb_front #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 8,
  parameter int unsigned SUM_W               = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ttrgb_sample_if.sink          sample_i,
  output logic                  push_valid_o,
  input  wire logic             push_ready_i,
  output logic [SUM_W-1:0]      push_sum_o
);
  import ttrgb_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             last;
  logic             xfer;

  assign last           = (count_q == CNT_LAST);
  assign sample_i.ready = !last || push_ready_i;
  assign xfer           = sample_i.valid && sample_i.ready;
  assign push_valid_o   = sample_i.valid && last;
  assign push_sum_o     = sum_q + SUM_W'(sample_i.sample);

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (xfer) begin
      if (last) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
        sum_d   = push_sum_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

endmodule
`default_nettype wire

### rtl/ttrgb_queue.sv
`default_nettype none
module ttrgb_queue #(
  parameter int unsigned WIDTH = 13
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [WIDTH-1:0]  push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic [WIDTH-1:0]       pop_data_o
);
  import ttrgb_pkg::*;

  localparam logic [QPTR_W:0] FILL_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != FILL_FULL);
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/ttrgb_back.sv
`default_nettype none
module ttrgb_back #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 8,
  parameter int unsigned SUM_W               = 13
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           pop_valid_i,
  output logic                                pop_ready_o,
  input  wire logic [SUM_W-1:0]               pop_sum_i,
  input  wire logic [ttrgb_pkg::SCALE_W-1:0]  temp_scale_i,
  ttrgb_result_if.source                      result_o
);
  import ttrgb_pkg::*;

  localparam int unsigned PROD_W  = 2 * SUM_W;
  localparam logic [SUM_W-1:0] AVG_MUL = SUM_W'((2 ** SUM_W) / SAMPLES_PER_AVERAGE);
  localparam logic [SUM_W-1:0] AVG_DIV = SUM_W'(SAMPLES_PER_AVERAGE);
  localparam int unsigned SPROD_W = SAMPLE_W + SCALE_W;
  localparam int unsigned RPROD_W = 2 * NUM_W;

  be_state_e state_q, state_d;
  logic      load_out;

  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic [TEMP_W-1:0]   temp_q;
  logic [NUM_W-1:0]    r_num_q, g_num_q, b_num_q;
  logic [DUTY_W-1:0]   r_est_q, g_est_q, b_est_q;
  logic                out_valid_q;
  logic [TEMP_W-1:0]   out_temp_q;
  logic [DUTY_W-1:0]   out_red_q, out_green_q, out_blue_q;

  logic [PROD_W-1:0]   avg_prod;
  logic [SUM_W-1:0]    avg_rem;
  logic [SAMPLE_W-1:0] avg_fix;
  logic [SPROD_W-1:0]  scaled;
  logic [NUM_W-1:0]    r_num_d, g_num_d, b_num_d, g_dn;
  logic [RPROD_W-1:0]  r_prod, g_prod, b_prod;
  logic [NUM_W-1:0]    r_rem, g_rem, b_rem;
  logic [DUTY_W-1:0]   r_quo, g_quo, b_quo;
  logic [DUTY_W-1:0]   red_d, green_d, blue_d;

  // Block average: reciprocal estimate, then one correction step
  assign avg_prod = PROD_W'(sum_q) * PROD_W'(AVG_MUL);
  assign avg_rem  = sum_q - SUM_W'(avg_q) * AVG_DIV;
  assign avg_fix  = (avg_rem >= AVG_DIV) ? avg_q + SAMPLE_W'(1) : avg_q;

  assign scaled = SPROD_W'(avg_q) * SPROD_W'(temp_scale_i);

  always_comb begin
    r_num_d = '0;
    g_num_d = '0;
    b_num_d = '0;
    g_dn    = NUM_W'(temp_q - TEMP_W'(GREEN_PEAK)) * NUM_W'(SLOPE_DOWN);
    if (temp_q >= TEMP_W'(RED_LO) && temp_q <= TEMP_W'(RED_HI)) begin
      r_num_d = NUM_W'(temp_q - TEMP_W'(RED_LO)) * NUM_W'(SLOPE_UP);
    end
    if (temp_q > TEMP_W'(GREEN_LO) && temp_q <= TEMP_W'(GREEN_PEAK)) begin
      g_num_d = NUM_W'(temp_q - TEMP_W'(GREEN_LO)) * NUM_W'(SLOPE_UP);
    end else if (temp_q > TEMP_W'(GREEN_PEAK) && temp_q <= TEMP_W'(GREEN_HI)) begin
      g_num_d = g_dn >> 1;
    end
    if (temp_q <= TEMP_W'(BLUE_HI)) begin
      b_num_d = NUM_W'(temp_q) * NUM_W'(SLOPE_DOWN);
    end
  end

  assign r_prod = RPROD_W'(r_num_q) * RPROD_W'(RECIP_RED);
  assign g_prod = RPROD_W'(g_num_q) * RPROD_W'(RECIP_GREEN);
  assign b_prod = RPROD_W'(b_num_q) * RPROD_W'(RECIP_BLUE);

  assign r_rem = r_num_q - NUM_W'(r_est_q) * NUM_W'(DIV_RED);
  assign g_rem = g_num_q - NUM_W'(g_est_q) * NUM_W'(DIV_GREEN);
  assign b_rem = b_num_q - NUM_W'(b_est_q) * NUM_W'(DIV_BLUE);
  assign r_quo = (r_rem >= NUM_W'(DIV_RED))   ? r_est_q + DUTY_W'(1) : r_est_q;
  assign g_quo = (g_rem >= NUM_W'(DIV_GREEN)) ? g_est_q + DUTY_W'(1) : g_est_q;
  assign b_quo = (b_rem >= NUM_W'(DIV_BLUE))  ? b_est_q + DUTY_W'(1) : b_est_q;

  always_comb begin
    if (temp_q < TEMP_W'(RED_LO)) begin
      red_d = '0;
    end else if (temp_q <= TEMP_W'(RED_HI)) begin
      red_d = r_quo + DUTY_W'(1);
    end else begin
      red_d = DUTY_FULL;
    end
    if (temp_q <= TEMP_W'(GREEN_LO)) begin
      green_d = '0;
    end else if (temp_q <= TEMP_W'(GREEN_PEAK)) begin
      green_d = g_quo + DUTY_W'(1);
    end else if (temp_q <= TEMP_W'(GREEN_HI)) begin
      green_d = DUTY_FULL - g_quo;
    end else begin
      green_d = '0;
    end
    if (temp_q <= TEMP_W'(BLUE_HI)) begin
      blue_d = DUTY_FULL - b_quo;
    end else begin
      blue_d = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      BE_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = BE_AVG_EST;
        end
      end
      BE_AVG_EST:  state_d = BE_AVG_FIX;
      BE_AVG_FIX:  state_d = BE_SCALE;
      BE_SCALE:    state_d = BE_RAMP_NUM;
      BE_RAMP_NUM: state_d = BE_RAMP_EST;
      BE_RAMP_EST: state_d = BE_RAMP_FIX;
      BE_RAMP_FIX: begin
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_IDLE: begin
        if (pop_valid_i) begin
          sum_q <= pop_sum_i;
        end
      end
      BE_AVG_EST: avg_q  <= avg_prod[SUM_W +: SAMPLE_W];
      BE_AVG_FIX: avg_q  <= avg_fix;
      BE_SCALE:   temp_q <= scaled[SCALE_W +: TEMP_W];
      BE_RAMP_NUM: begin
        r_num_q <= r_num_d;
        g_num_q <= g_num_d;
        b_num_q <= b_num_d;
      end
      BE_RAMP_EST: begin
        r_est_q <= r_prod[NUM_W +: DUTY_W];
        g_est_q <= g_prod[NUM_W +: DUTY_W];
        b_est_q <= b_prod[NUM_W +: DUTY_W];
      end
      default: ;
    endcase
    if (load_out) begin
      out_temp_q  <= temp_q;
      out_red_q   <= red_d;
      out_green_q <= green_d;
      out_blue_q  <= blue_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.temperature = out_temp_q;
  assign result_o.red_duty    = out_red_q;
  assign result_o.green_duty  = out_green_q;
  assign result_o.blue_duty   = out_blue_q;

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import ttrgb_pkg::*;

  localparam int unsigned SAMPLES_PER_BLOCK = 8;
  localparam int unsigned CLK_HALF          = 4;
  localparam int unsigned RESET_CYCLES      = 11;
  localparam int unsigned SETTLE_CYCLES     = 12;
  localparam int unsigned HOLD_AT_SAMPLE    = 600;
  localparam int unsigned HOLD_CYCLES       = 300;
  localparam int unsigned PHASE_SAMPLES     = 210;
  localparam int unsigned TIMEOUT_CYCLES    = 400000;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } colour_t;

  class duty_scoreboard;
    logic [SCALE_W-1:0] gain;
    int unsigned        blk_sum;
    int unsigned        blk_cnt;
    int unsigned        samples_taken;
    int unsigned        errors;
    colour_t            colour_q[$];

    function new();
      gain          = TEMP_SCALE_RST;
      blk_sum       = 0;
      blk_cnt       = 0;
      samples_taken = 0;
      errors        = 0;
    endfunction

    function int unsigned pending();
      return colour_q.size();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned avg;
      int unsigned t;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      colour_t     c;
      samples_taken++;
      blk_sum += s;
      blk_cnt++;
      if (blk_cnt == SAMPLES_PER_BLOCK) begin
        avg     = blk_sum / SAMPLES_PER_BLOCK;
        blk_sum = 0;
        blk_cnt = 0;
        t = ((avg * gain) >> 16) & 32'h3FF;

        if (t < RED_LO) r = 0;
        else if (t <= RED_HI) r = (t - RED_LO) * SLOPE_UP / DIV_RED + 1;
        else r = DUTY_FULL;

        if (t <= GREEN_LO) g = 0;
        else if (t <= GREEN_PEAK) g = (t - GREEN_LO) * SLOPE_UP / DIV_GREEN + 1;
        else if (t <= GREEN_HI) g = DUTY_FULL - (t - GREEN_PEAK) * SLOPE_DOWN / (GREEN_HI - GREEN_PEAK);
        else g = 0;

        if (t == 0) b = DUTY_FULL;
        else if (t <= BLUE_HI) b = DUTY_FULL - t * SLOPE_DOWN / DIV_BLUE;
        else b = 0;

        c.temperature = TEMP_W'(t);
        c.red         = DUTY_W'(r);
        c.green       = DUTY_W'(g);
        c.blue        = DUTY_W'(b);
        colour_q.push_back(c);
      end
    endfunction

    function void check_result(colour_t got);
      colour_t want;
      if (colour_q.size() == 0) begin
        $error("result with no block pending: temperature %0d", got.temperature);
        errors++;
        return;
      end
      want = colour_q.pop_front();
      if (got.temperature !== want.temperature) begin
        $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
        errors++;
      end
      if (got.red !== want.red) begin
        $error("red_duty: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green_duty: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue_duty: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ttrgb_cfg_if    cfg_if();
  ttrgb_sample_if smp_if();
  ttrgb_result_if res_if();

  temp_to_rgb_duty_mapper #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_BLOCK)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .sample_i(smp_if),
    .result_o(res_if)
  );

  duty_scoreboard sb = new();

  int unsigned blk_pos    = 0;
  int          blk_centre = 0;
  int          blk_spread = 0;
  bit          blk_noise  = 1'b0;

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
    sb.note_sample(s);
    blk_pos = (blk_pos + 1) % SAMPLES_PER_BLOCK;
    @(negedge clk_i);
  endtask

  task automatic idle(input int unsigned cycles);
    smp_if.valid  <= 1'b0;
    smp_if.sample <= SAMPLE_W'($urandom);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    smp_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    cfg_if.valid      <= 1'b1;
    cfg_if.temp_scale <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.gain = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned kind;
    int unsigned tgt;
    int          lvl;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        if (blk_pos == 0) begin
          kind      = $urandom_range(0, 9);
          blk_noise = (kind < 3);
          if (kind == 3) begin
            blk_centre = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            blk_spread = 0;
          end else begin
            tgt = $urandom_range(0, 100);
            if (sb.gain == 0) blk_centre = $urandom_range(0, SAMPLE_MAX);
            else blk_centre = ((tgt << 16) + sb.gain - 1) / sb.gain;
            if (blk_centre > SAMPLE_MAX) blk_centre = SAMPLE_MAX;
            blk_spread = $urandom_range(0, 3);
          end
        end
        if (blk_noise) begin
          lvl = $urandom_range(0, SAMPLE_MAX);
        end else begin
          lvl = blk_centre + int'($urandom_range(0, 2 * blk_spread)) - blk_spread;
          if (lvl < 0) lvl = 0;
          if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;
        end
        send_sample(SAMPLE_W'(lvl));
        sent++;
      end
      if ($urandom_range(0, 5) != 0) idle($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    logic [SCALE_W-1:0] scales[7];
    scales = '{16'hFFFF, 16'h0000, TEMP_SCALE_RST, 16'h0001, SCALE_W'($urandom),
               16'd8000, SCALE_W'($urandom)};
    rst_ni            = 1'b0;
    smp_if.valid      = 1'b0;
    smp_if.sample     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.temp_scale = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full scale, zero, red ramp start, then an open block
    repeat (SAMPLES_PER_BLOCK) send_sample(SAMPLE_W'(SAMPLE_MAX));
    idle(3);
    repeat (SAMPLES_PER_BLOCK) send_sample('0);
    repeat (SAMPLES_PER_BLOCK) send_sample(SAMPLE_W'(140));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();

    foreach (scales[i]) begin
      write_scale(scales[i]);
      run_phase(PHASE_SAMPLES);
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    bit          held;
    res_if.ready = 1'b0;
    mode         = 0;
    mode_left    = 0;
    held         = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.samples_taken >= HOLD_AT_SAMPLE) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        0: begin
          res_if.ready <= 1'b1;
        end
        1: begin
          res_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          res_if.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  initial begin : result_monitor
    colour_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.temperature = res_if.temperature;
        got.red         = res_if.red_duty;
        got.green       = res_if.green_duty;
        got.blue        = res_if.blue_duty;
        sb.check_result(got);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
